FILE: design/dce_pkg.sv
`timescale 1ns / 1ps
package dce_pkg;

  localparam int MAX_POINTS = 256;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int CNT_W      = PT_AW + 1;
  localparam int MAX_DIMS   = 4;
  localparam int DIM_AW     = $clog2(MAX_DIMS);
  localparam int COORD_W    = 16;
  localparam int LABEL_W    = 10;
  localparam int EPS_W      = 36;
  localparam int MINP_W     = 9;
  localparam int DIMS_W     = 3;
  localparam int SQ_W       = 2 * (COORD_W + 1);
  localparam int CFG_IDX_W  = 2;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_EPS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MINP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS = 2'd2;

  localparam logic [1:0] SRC_P   = 2'd0;
  localparam logic [1:0] SRC_J   = 2'd1;
  localparam logic [1:0] SRC_Q   = 2'd2;
  localparam logic [1:0] SRC_IDX = 2'd3;

  localparam logic [1:0] ACT_COUNT = 2'd0;
  localparam logic [1:0] ACT_MARK1 = 2'd1;
  localparam logic [1:0] ACT_CNTQ  = 2'd2;
  localparam logic [1:0] ACT_MARK2 = 2'd3;

  localparam logic signed [LABEL_W-1:0] LABEL_NOISE = -10'sd1;

  typedef struct packed {
    logic       capture;
    logic       clr_points;
    logic       clr_labels;
    logic       init_run;
    logic       load_pt;
    logic       rd_pt;
    logic [1:0] pt_src;
    logic       rd_lbl;
    logic [1:0] lbl_src;
    logic       rd_q;
    logic       lat_center;
    logic       start_scan;
    logic       init_queue;
    logic       dist_init;
    logic       dist_mul;
    logic       dist_acc;
    logic       do_act;
    logic [1:0] act;
    logic       noise_p;
    logic       next_p;
    logic       next_cluster;
  } dce_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       p_done;
    logic       scan_done;
    logic       label_nz;
    logic       dim_last;
    logic       queue_empty;
    logic       few;
  } dce_stat_t;

endpackage

FILE: design/dce_datapath.sv
`timescale 1ns / 1ps
module dce_datapath import dce_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  dce_cmd_t                     cmd,
  output dce_stat_t                    stat,
  input  logic [1:0]                   item_op,
  input  logic [PT_AW-1:0]             item_index,
  input  logic [MAX_DIMS*COORD_W-1:0]  item_coords,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_idx,
  input  logic [EPS_W-1:0]             cfg_val,
  output logic [CNT_W-1:0]             res_cluster_count,
  output logic signed [LABEL_W-1:0]    res_label,
  output logic                         res_noise,
  output logic                         res_caperr
);

  logic [MAX_DIMS*COORD_W-1:0] pmem [MAX_POINTS];
  logic [LABEL_W-1:0]          lmem [MAX_POINTS];
  logic [PT_AW-1:0]            qmem [MAX_POINTS];
  logic [MAX_POINTS-1:0]       lvld;

  logic [EPS_W-1:0]  eps;
  logic [MINP_W-1:0] minp;
  logic [DIMS_W-1:0] dims;

  logic [1:0]                  op_q;
  logic [PT_AW-1:0]            idx_q;
  logic [MAX_DIMS*COORD_W-1:0] crd_q;
  logic                        cap_q;

  logic [CNT_W-1:0] pcnt, cc, p, j, head, tail, nbr;
  logic [MAX_DIMS*COORD_W-1:0] pj, cen;
  logic [LABEL_W-1:0] lbl_rd;
  logic               lv_rd;
  logic [PT_AW-1:0]   q_rd;
  logic [DIM_AW-1:0]  dim, dim_top;
  logic [SQ_W-1:0]    sq;
  logic [EPS_W-1:0]   acc;

  logic signed [LABEL_W-1:0] eff;
  logic signed [COORD_W:0]   diff;
  logic signed [SQ_W-1:0]    prod;
  logic [PT_AW-1:0]          pt_addr, lbl_addr;
  logic                      near, full;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps  <= '0;
      minp <= MINP_W'(3);
      dims <= DIMS_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_EPS:  eps  <= cfg_val;
        CFG_MINP: minp <= cfg_val[MINP_W-1:0];
        CFG_DIMS: dims <= cfg_val[DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dims == '0) dim_top = '0;
    else if (dims > DIMS_W'(MAX_DIMS)) dim_top = DIM_AW'(MAX_DIMS - 1);
    else dim_top = DIM_AW'(dims - 1'b1);
  end

  assign eff  = lv_rd ? signed'(lbl_rd) : '0;
  assign full = (pcnt == CNT_W'(MAX_POINTS));
  assign near = (acc < eps);

  always_comb begin
    unique case (cmd.pt_src)
      SRC_P:   pt_addr = p[PT_AW-1:0];
      SRC_J:   pt_addr = j[PT_AW-1:0];
      SRC_Q:   pt_addr = q_rd;
      default: pt_addr = idx_q;
    endcase
    unique case (cmd.lbl_src)
      SRC_P:   lbl_addr = p[PT_AW-1:0];
      SRC_J:   lbl_addr = j[PT_AW-1:0];
      SRC_Q:   lbl_addr = q_rd;
      default: lbl_addr = idx_q;
    endcase
  end

  assign diff = signed'({pj[dim*COORD_W+COORD_W-1], pj[dim*COORD_W +: COORD_W]})
              - signed'({cen[dim*COORD_W+COORD_W-1], cen[dim*COORD_W +: COORD_W]});
  assign prod = diff * diff;

  // Memories: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (cmd.load_pt && !full) pmem[pcnt[PT_AW-1:0]] <= crd_q;
    if (cmd.rd_pt) pj <= pmem[pt_addr];
    if (cmd.rd_lbl) lbl_rd <= lmem[lbl_addr];
    if (cmd.rd_q) q_rd <= qmem[head[PT_AW-1:0]];
    if (cmd.noise_p) lmem[p[PT_AW-1:0]] <= LABEL_NOISE;
    else if (cmd.do_act && near &&
             (cmd.act == ACT_MARK1 || (cmd.act == ACT_MARK2 && eff < 1)))
      lmem[j[PT_AW-1:0]] <= LABEL_W'(cc);
    if (cmd.do_act && near && tail < CNT_W'(MAX_POINTS) &&
        ((cmd.act == ACT_MARK1 && j != p) || (cmd.act == ACT_MARK2 && eff == 0)))
      qmem[tail[PT_AW-1:0]] <= j[PT_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvld <= '0;
      lv_rd <= 1'b0;
    end else begin
      if (cmd.rd_lbl) lv_rd <= lvld[lbl_addr];
      if (cmd.clr_labels || cmd.init_run) lvld <= '0;
      else if (cmd.noise_p) lvld[p[PT_AW-1:0]] <= 1'b1;
      else if (cmd.do_act && near &&
               (cmd.act == ACT_MARK1 || (cmd.act == ACT_MARK2 && eff < 1)))
        lvld[j[PT_AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_q <= item_index;
      crd_q <= item_coords;
    end
    if (cmd.load_pt) cap_q <= full;
    if (cmd.lat_center) cen <= pj;
    if (cmd.dist_init) begin
      acc <= '0;
      dim <= '0;
    end
    if (cmd.dist_mul) sq <= unsigned'(prod);
    if (cmd.dist_acc) begin
      acc <= acc + EPS_W'(sq);
      if (dim != dim_top) dim <= dim + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= OP_CLEAR;
      pcnt <= '0;
      cc   <= CNT_W'(1);
      p    <= '0;
      j    <= '0;
      head <= '0;
      tail <= '0;
      nbr  <= '0;
    end else begin
      if (cmd.capture) op_q <= item_op;
      if (cmd.clr_points) pcnt <= '0;
      else if (cmd.load_pt && !full) pcnt <= pcnt + 1'b1;
      if (cmd.clr_labels || cmd.init_run) cc <= CNT_W'(1);
      else if (cmd.next_cluster) cc <= cc + 1'b1;
      if (cmd.init_run) p <= '0;
      else if (cmd.next_p) p <= p + 1'b1;
      if (cmd.start_scan) begin
        j   <= '0;
        nbr <= '0;
      end else if (cmd.do_act) begin
        j <= j + 1'b1;
        if (near && (cmd.act == ACT_COUNT || cmd.act == ACT_CNTQ)) nbr <= nbr + 1'b1;
      end
      if (cmd.init_queue) begin
        head <= '0;
        tail <= '0;
      end else begin
        if (cmd.rd_q) head <= head + 1'b1;
        if (cmd.do_act && near && tail < CNT_W'(MAX_POINTS) &&
            ((cmd.act == ACT_MARK1 && j != p) || (cmd.act == ACT_MARK2 && eff == 0)))
          tail <= tail + 1'b1;
      end
    end
  end

  assign stat.op          = op_q;
  assign stat.p_done      = (p >= pcnt);
  assign stat.scan_done   = (j >= pcnt);
  assign stat.label_nz    = (eff != 0);
  assign stat.dim_last    = (dim == dim_top);
  assign stat.queue_empty = (head >= tail);
  assign stat.few         = (MINP_W'(nbr) < minp);

  assign res_cluster_count = cc - 1'b1;
  assign res_label  = (op_q == OP_READ) ? eff : '0;
  assign res_noise  = (op_q == OP_READ) && (eff == LABEL_NOISE);
  assign res_caperr = (op_q == OP_LOAD) && cap_q;

  a_tail_max: assert property (@(posedge clk) disable iff (rst)
    tail <= CNT_W'(MAX_POINTS)) else $error("seed queue overfilled");
  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_q |-> head < tail) else $error("seed queue read while empty");
  a_pcnt_max: assert property (@(posedge clk) disable iff (rst)
    pcnt <= CNT_W'(MAX_POINTS)) else $error("point count beyond capacity");

endmodule

FILE: design/dce_ctrl.sv
`timescale 1ns / 1ps
module dce_ctrl import dce_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_free,
  output logic      resp_load,
  input  dce_stat_t stat,
  output dce_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_LOAD = 4'd2;
  localparam logic [3:0] S_RDL  = 4'd3;
  localparam logic [3:0] S_RUN  = 4'd4;
  localparam logic [3:0] S_PTOP = 4'd5;
  localparam logic [3:0] S_PCHK = 4'd6;
  localparam logic [3:0] S_SCAN = 4'd7;
  localparam logic [3:0] S_DMUL = 4'd8;
  localparam logic [3:0] S_DACC = 4'd9;
  localparam logic [3:0] S_DCMP = 4'd10;
  localparam logic [3:0] S_QTOP = 4'd11;
  localparam logic [3:0] S_QRD  = 4'd12;
  localparam logic [3:0] S_QLD  = 4'd13;
  localparam logic [3:0] S_RESP = 4'd14;

  logic [3:0] state, state_next;
  logic [1:0] mode, mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= ACT_COUNT;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.act    = mode;
    state_next = state;
    mode_next  = mode;
    resp_load  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CLR;
        end
      end
      S_CLR: begin
        unique case (stat.op)
          OP_CLEAR: begin
            cmd.clr_points = 1'b1;
            cmd.clr_labels = 1'b1;
            state_next = S_IDLE;
          end
          OP_LOAD: state_next = S_LOAD;
          OP_RUN:  state_next = S_RUN;
          default: state_next = S_RDL;
        endcase
      end
      S_LOAD: begin
        cmd.load_pt = 1'b1;
        state_next  = S_RESP;
      end
      S_RDL: begin
        cmd.rd_lbl  = 1'b1;
        cmd.lbl_src = SRC_IDX;
        state_next  = S_RESP;
      end
      S_RUN: begin
        cmd.init_run = 1'b1;
        state_next   = S_PTOP;
      end
      S_PTOP: begin
        if (stat.p_done) begin
          state_next = S_RESP;
        end else begin
          cmd.rd_lbl  = 1'b1;
          cmd.lbl_src = SRC_P;
          cmd.rd_pt   = 1'b1;
          cmd.pt_src  = SRC_P;
          state_next  = S_PCHK;
        end
      end
      S_PCHK: begin
        if (stat.label_nz) begin
          cmd.next_p = 1'b1;
          state_next = S_PTOP;
        end else begin
          cmd.lat_center = 1'b1;
          cmd.start_scan = 1'b1;
          cmd.init_queue = 1'b1;
          mode_next  = ACT_COUNT;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          unique case (mode)
            ACT_COUNT: begin
              if (stat.few) begin
                cmd.noise_p = 1'b1;
                cmd.next_p  = 1'b1;
                state_next  = S_PTOP;
              end else begin
                cmd.start_scan = 1'b1;
                mode_next  = ACT_MARK1;
                state_next = S_SCAN;
              end
            end
            ACT_CNTQ: begin
              if (stat.few) begin
                state_next = S_QTOP;
              end else begin
                cmd.start_scan = 1'b1;
                mode_next  = ACT_MARK2;
                state_next = S_SCAN;
              end
            end
            default: state_next = S_QTOP;
          endcase
        end else begin
          cmd.rd_pt     = 1'b1;
          cmd.pt_src    = SRC_J;
          cmd.rd_lbl    = 1'b1;
          cmd.lbl_src   = SRC_J;
          cmd.dist_init = 1'b1;
          state_next    = S_DMUL;
        end
      end
      S_DMUL: begin
        cmd.dist_mul = 1'b1;
        state_next   = S_DACC;
      end
      S_DACC: begin
        cmd.dist_acc = 1'b1;
        state_next   = stat.dim_last ? S_DCMP : S_DMUL;
      end
      S_DCMP: begin
        cmd.do_act = 1'b1;
        state_next = S_SCAN;
      end
      S_QTOP: begin
        if (stat.queue_empty) begin
          cmd.next_cluster = 1'b1;
          cmd.next_p       = 1'b1;
          state_next       = S_PTOP;
        end else begin
          cmd.rd_q   = 1'b1;
          state_next = S_QRD;
        end
      end
      S_QRD: begin
        cmd.rd_pt  = 1'b1;
        cmd.pt_src = SRC_Q;
        state_next = S_QLD;
      end
      S_QLD: begin
        cmd.lat_center = 1'b1;
        cmd.start_scan = 1'b1;
        mode_next  = ACT_CNTQ;
        state_next = S_SCAN;
      end
      S_RESP: begin
        if (out_free) begin
          resp_load  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_resp_free: assert property (@(posedge clk) disable iff (rst)
    resp_load |-> out_free) else $error("result loaded over a pending one");
  a_act_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.do_act |=> state == S_SCAN) else $error("compare not followed by scan");
  a_dist_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.dist_mul |=> cmd.dist_acc) else $error("square not accumulated");

endmodule

FILE: design/density_cluster_engine_core.sv
`timescale 1ns / 1ps
// Clear passes through S_CLR with no result beat; load and read pass S_LOAD or S_RDL
// and S_RESP to the result beat. A run scans all N stored points per unlabelled point
// and per queued seed, and again to mark them when dense; each pairwise distance sums
// the squared differences of the D active dimensions through one shared multiplier.
// One item is worked at a time; the next item is taken while a result waits.
// Synchronous reset clears counters, label valid bits and config to defaults.
module density_cluster_engine_core import dce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // point_index[7:0], coord_0[23:8], coord_1[39:24], coord_2[55:40], coord_3[71:56]
  input  logic [71:0]          s_tdata,
  // op[1:0]
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // cluster_count[8:0], point_label[18:9], is_noise[19], capacity_error[20]
  output logic [23:0]          m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [EPS_W-1:0]     cfg_data
);

  dce_cmd_t  cmd;
  dce_stat_t stat;
  logic      resp_load, out_free;
  logic [CNT_W-1:0]          res_cc;
  logic signed [LABEL_W-1:0] res_label;
  logic                      res_noise, res_caperr;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  dce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_free  (out_free),
    .resp_load (resp_load),
    .stat      (stat),
    .cmd       (cmd)
  );

  dce_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .item_op           (s_tuser),
    .item_index        (s_tdata[PT_AW-1:0]),
    .item_coords       (s_tdata[8 +: MAX_DIMS*COORD_W]),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_idx           (cfg_index),
    .cfg_val           (cfg_data),
    .res_cluster_count (res_cc),
    .res_label         (res_label),
    .res_noise         (res_noise),
    .res_caperr        (res_caperr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (resp_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) m_tdata <= {3'b000, res_caperr, res_noise, res_label, res_cc};
  end

endmodule

FILE: sim/density_cluster_engine_core_test.sv
`timescale 1ns / 1ps
module density_cluster_engine_core_test;
  import dce_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]         op;
    logic [7:0]         idx;
    logic signed [15:0] crd [4];
  } dce_item_t;

  typedef struct packed {
    logic [8:0] count;
    logic [9:0] label;
    logic       noise;
    logic       cap_err;
  } dce_res_t;

  typedef struct {
    dce_item_t item;
    bit        typed;
    dce_res_t  res;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [71:0]       s_tdata = '0;
  logic [1:0]        s_tuser = OP_CLEAR;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [23:0]       m_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_EPS;
  logic [EPS_W-1:0]  cfg_data = '0;

  density_cluster_engine_core dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the engine state.
  logic signed [15:0] pt_coord [MAX_POINTS][MAX_DIMS];
  int                 pt_label [MAX_POINTS];
  int                 pt_total;
  int                 next_cluster;
  logic [EPS_W-1:0]   eps_reg;
  logic [MINP_W-1:0]  minp_reg;
  logic [DIMS_W-1:0]  dims_reg;

  dce_res_t results_due [$];
  int       fails;
  int       items_sent;
  int       results_seen;
  int       runs_done;
  int       max_clusters;
  int       cycles = 0;

  function automatic bit within_eps(int a, int b, int dims);
    longint unsigned sum;
    longint diff;
    sum = 0;
    for (int d = 0; d < dims; d++) begin
      diff = longint'(pt_coord[a][d]) - longint'(pt_coord[b][d]);
      if (diff < 0) diff = -diff;
      sum += longint'(diff) * longint'(diff);
    end
    return sum < {28'd0, eps_reg};
  endfunction

  function automatic int neighbor_count(int p, int dims);
    int c;
    c = 0;
    for (int j = 0; j < pt_total; j++)
      if (within_eps(j, p, dims)) c++;
    return c;
  endfunction

  function automatic void cluster_points();
    int dims;
    int head;
    int tail;
    int c;
    int q;
    int seeds [MAX_POINTS];
    dims = (dims_reg == 0) ? 1 : (dims_reg > MAX_DIMS) ? MAX_DIMS : int'(dims_reg);
    foreach (pt_label[i]) pt_label[i] = 0;
    next_cluster = 1;
    for (int p = 0; p < pt_total; p++) begin
      if (pt_label[p] != 0) continue;
      if (neighbor_count(p, dims) < int'(minp_reg)) begin
        pt_label[p] = -1;
        continue;
      end
      head = 0;
      tail = 0;
      c = next_cluster;
      for (int j = 0; j < pt_total; j++)
        if (within_eps(j, p, dims)) begin
          pt_label[j] = c;
          if (j != p && tail < MAX_POINTS) seeds[tail++] = j;
        end
      while (head < tail) begin
        q = seeds[head++];
        if (neighbor_count(q, dims) < int'(minp_reg)) continue;
        for (int j = 0; j < pt_total; j++)
          if (within_eps(j, q, dims) && pt_label[j] < 1) begin
            if (pt_label[j] == 0 && tail < MAX_POINTS) seeds[tail++] = j;
            pt_label[j] = c;
          end
      end
      next_cluster++;
    end
  endfunction

  // Updates the shadow state; returns 1 when the item produces a result beat.
  function automatic bit predict_item(dce_item_t it, output dce_res_t r);
    r = '0;
    case (it.op)
      OP_CLEAR: begin
        pt_total = 0;
        foreach (pt_label[i]) pt_label[i] = 0;
        next_cluster = 1;
        return 1'b0;
      end
      OP_LOAD: begin
        if (pt_total >= MAX_POINTS) r.cap_err = 1'b1;
        else begin
          for (int d = 0; d < MAX_DIMS; d++) pt_coord[pt_total][d] = it.crd[d];
          pt_total++;
        end
      end
      OP_RUN: begin
        cluster_points();
        runs_done++;
        if (next_cluster - 1 > max_clusters) max_clusters = next_cluster - 1;
      end
      default: begin
        r.label = pt_label[it.idx][9:0];
        r.noise = (pt_label[it.idx] == -1);
      end
    endcase
    r.count = 9'(next_cluster - 1);
    return 1'b1;
  endfunction

  int burst_left = 0;

  task automatic send_item(dce_item_t it, bit typed, dce_res_t typed_res);
    dce_res_t r;
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= {it.crd[3], it.crd[2], it.crd[1], it.crd[0], it.idx};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (predict_item(it, r)) results_due = {results_due, (typed ? typed_res : r)};
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 8);
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send(dce_item_t it);
    send_item(it, 1'b0, '0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [EPS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_EPS:  eps_reg  = val;
      CFG_MINP: minp_reg = val[MINP_W-1:0];
      default:  dims_reg = val[DIMS_W-1:0];
    endcase
  endtask

  task automatic drain();
    // The last beat may still be offered; take it down before waiting.
    s_tvalid <= 1'b0;
    wait (results_due.size() == 0);
    // A clear gives no beat, so leave it time to finish.
    repeat (10) @(posedge clk);
  endtask

  function automatic dce_item_t make_item(logic [1:0] op, logic [7:0] idx,
                                          logic signed [15:0] c0, logic signed [15:0] c1,
                                          logic signed [15:0] c2, logic signed [15:0] c3);
    dce_item_t it;
    it.op = op;
    it.idx = idx;
    it.crd[0] = c0;
    it.crd[1] = c1;
    it.crd[2] = c2;
    it.crd[3] = c3;
    return it;
  endfunction

  function automatic dce_item_t rand_load();
    return make_item(OP_LOAD, 8'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
  endfunction

  // Receiver stall pattern: switches at random between four ready modes.
  int stall_mode = 0;
  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 1);
      2: m_tready <= ($urandom_range(0, 7) == 0);
      default: m_tready <= (cycles % 16) < 12;
    endcase
  end

  always @(posedge clk) begin
    dce_res_t want;
    dce_res_t got;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      got = {m_tdata[8:0], m_tdata[18:9], m_tdata[19], m_tdata[20]};
      if (results_due.size() == 0) begin
        $error("result beat with nothing expected: %h", m_tdata);
        fails++;
      end else begin
        want = results_due.pop_front();
        if (got.count !== want.count) begin
          $error("cluster_count expected %0d got %0d", want.count, got.count);
          fails++;
        end
        if (got.label !== want.label) begin
          $error("point_label expected %0d got %0d", $signed(want.label), $signed(got.label));
          fails++;
        end
        if (got.noise !== want.noise) begin
          $error("is_noise expected %0d got %0d", want.noise, got.noise);
          fails++;
        end
        if (got.cap_err !== want.cap_err) begin
          $error("capacity_error expected %0d got %0d", want.cap_err, got.cap_err);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("density_cluster_engine_core test failed");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    dce_item_t it;
    int ncent;
    int spread;
    int npt;
    int rand_items;
    int phase;
    logic signed [15:0] cent [3][4];
    logic signed [15:0] ofs;
    logic [9:0] noise_lbl;

    fails = 0;
    items_sent = 0;
    results_seen = 0;
    runs_done = 0;
    max_clusters = 0;
    pt_total = 0;
    next_cluster = 1;
    foreach (pt_label[i]) pt_label[i] = 0;
    eps_reg = '0;
    minp_reg = 9'd3;
    dims_reg = 3'd2;
    noise_lbl = LABEL_NOISE;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows; eps is zero after reset, so every run point is noise.
    row = '{make_item(OP_READ, 8'd0, 0, 0, 0, 0), 1'b1, '{9'd0, 10'd0, 1'b0, 1'b0}};
    rows = {rows, row};
    row = '{make_item(OP_READ, 8'd255, 0, 0, 0, 0), 1'b1, '{9'd0, 10'd0, 1'b0, 1'b0}};
    rows = {rows, row};
    row = '{make_item(OP_RUN, 8'd0, 0, 0, 0, 0), 1'b1, '{9'd0, 10'd0, 1'b0, 1'b0}};
    rows = {rows, row};
    row = '{make_item(OP_LOAD, 8'h00, -32768, -32768, -32768, -32768), 1'b1, '0};
    rows = {rows, row};
    row = '{make_item(OP_LOAD, 8'hff, 32767, 32767, 32767, 32767), 1'b1, '0};
    rows = {rows, row};
    row = '{make_item(OP_LOAD, 8'h5a, 0, 0, 0, 0), 1'b1, '0};
    rows = {rows, row};
    row = '{make_item(OP_LOAD, 8'ha5, 256, -256, 1, -1), 1'b0, '0};
    rows = {rows, row};
    row = '{make_item(OP_RUN, 8'd0, 0, 0, 0, 0), 1'b0, '0};
    rows = {rows, row};
    row = '{make_item(OP_READ, 8'd0, 0, 0, 0, 0), 1'b1, '{9'd0, noise_lbl, 1'b1, 1'b0}};
    rows = {rows, row};
    row = '{make_item(OP_READ, 8'd3, 0, 0, 0, 0), 1'b0, '0};
    rows = {rows, row};
    row = '{make_item(OP_READ, 8'd4, 0, 0, 0, 0), 1'b1, '{9'd0, 10'd0, 1'b0, 1'b0}};
    rows = {rows, row};
    row = '{make_item(OP_CLEAR, 8'd0, 0, 0, 0, 0), 1'b0, '0};
    rows = {rows, row};
    row = '{make_item(OP_READ, 8'd0, 0, 0, 0, 0), 1'b1, '{9'd0, 10'd0, 1'b0, 1'b0}};
    rows = {rows, row};
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].res);
    drain();

    // Fill the store past capacity; the last load must be dropped.
    send(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
    repeat (MAX_POINTS + 1) send(rand_load());
    repeat (4) send(make_item(OP_READ, 8'($urandom), 0, 0, 0, 0));
    send(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
    drain();

    rand_items = 0;
    phase = 0;
    while (rand_items < 100) begin
      spread = $urandom_range(1, 1024);
      case (phase)
        0: begin
          write_reg(CFG_EPS, {EPS_W{1'b1}});
          write_reg(CFG_MINP, 9'd1);
          write_reg(CFG_DIMS, 3'd4);
        end
        1: begin
          // Zero radius with no density demand opens one empty cluster per point.
          write_reg(CFG_EPS, '0);
          write_reg(CFG_MINP, 9'd0);
          write_reg(CFG_DIMS, 3'd7);
        end
        2: begin
          write_reg(CFG_EPS, 36'd1);
          write_reg(CFG_MINP, 9'd256);
          write_reg(CFG_DIMS, 3'd0);
        end
        3: begin
          write_reg(CFG_EPS, {EPS_W{1'b1}});
          write_reg(CFG_MINP, 9'd511);
          write_reg(CFG_DIMS, 3'd3);
        end
        default: begin
          write_reg(CFG_EPS, $urandom_range(0, 7) == 0 ? {EPS_W{1'b1}} :
                    36'(spread * spread * $urandom_range(1, 4)));
          write_reg(CFG_MINP, $urandom_range(1, 5));
          write_reg(CFG_DIMS, $urandom_range(1, 4));
        end
      endcase
      phase++;

      send(make_item(OP_CLEAR, 8'($urandom), 0, 0, 0, 0));
      ncent = $urandom_range(1, 3);
      for (int c = 0; c < 3; c++)
        for (int d = 0; d < 4; d++) cent[c][d] = 16'($urandom);
      npt = $urandom_range(1, 16);
      for (int k = 0; k < npt; k++) begin
        it = make_item(OP_LOAD, 8'($urandom), 0, 0, 0, 0);
        for (int d = 0; d < 4; d++) begin
          ofs = 16'($urandom_range(0, 2 * spread) - spread);
          it.crd[d] = cent[$urandom_range(0, ncent - 1)][d] + ofs;
        end
        if ($urandom_range(0, 9) == 0) it = rand_load();
        send(it);
        rand_items++;
        if ($urandom_range(0, 11) == 0) begin
          send(make_item(OP_READ, 8'($urandom), 0, 0, 0, 0));
          rand_items++;
        end
      end
      send(make_item(OP_RUN, 8'($urandom), 16'($urandom), 0, 0, 0));
      rand_items++;
      repeat ($urandom_range(3, 6)) begin
        send(make_item(OP_READ, $urandom_range(0, 3) == 0 ? 8'($urandom) :
                       8'($urandom_range(0, npt - 1)), 16'($urandom), 0, 0, 0));
        rand_items++;
      end
      drain();
    end

    wait (results_due.size() == 0);
    repeat (50) @(posedge clk);
    $display("Sent %0d items over %0d config phases, %0d clustering runs.",
             items_sent, phase, runs_done);
    $display("Checked %0d result beats; largest cluster count seen was %0d.",
             results_seen, max_clusters);
    if (fails == 0) begin
      $display("density_cluster_engine_core test passed");
    end else begin
      $display("density_cluster_engine_core test failed");
    end
    $finish;
  end

endmodule
